[rtl/egcd_pkg.sv]
`timescale 1ns / 1ps

package egcd_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int MAG_WIDTH  = DATA_WIDTH - 1;
    localparam int CNT_WIDTH  = (MAG_WIDTH > 1) ? $clog2(MAG_WIDTH) : 1;

    typedef logic [MAG_WIDTH-1:0] mag_t;
    typedef logic [CNT_WIDTH-1:0] bit_cnt_t;

    // handshake between sequencer and remainder unit
    typedef struct packed {
        logic start;
    } mod_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mod_stat_t;

endpackage

[rtl/euclid_gcd_unit.sv]
`timescale 1ns / 1ps

// Channel   Direction  Ports
// s_        in         s_valid, s_ready, s_first_operand, s_second_operand
// m_        out        m_valid, m_ready, m_divisor_result, m_invalid_arg
//
// One item at a time; s_ready is high only while the sequencer is idle.
// Each remainder step runs the shared bit-serial unit; the sequencer
// repeats steps until the second operand reaches zero.
// A negative operand skips the remainder unit and goes straight to S_DONE.
// The result waits in an output register, so a stalled m_ready does not
// block the next item until its own result is ready.
// aresetn is synchronous; it clears the sequencer and the output valid.
module euclid_gcd_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [egcd_pkg::DATA_WIDTH-1:0] s_first_operand,
    input  logic [egcd_pkg::DATA_WIDTH-1:0] s_second_operand,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [egcd_pkg::MAG_WIDTH-1:0]  m_divisor_result,
    output logic                            m_invalid_arg
);
    import egcd_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_START = 2'd1;
    localparam logic [1:0] S_WAIT  = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0] state_reg, state_next;
    mag_t       x_reg, x_next;
    mag_t       y_reg, y_next;
    logic       bad_reg, bad_next;
    logic       m_valid_reg, m_valid_next;
    mag_t       res_reg, res_next;
    logic       inv_reg, inv_next;

    mod_req_t   mod_req;
    mod_stat_t  mod_stat;
    mag_t       mod_rem;
    logic       s_accept;
    logic       out_free;

    egcd_mod_unit u_mod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req       (mod_req),
        .dividend  (x_reg),
        .divisor   (y_reg),
        .stat      (mod_stat),
        .remainder (mod_rem)
    );

    assign s_ready  = (state_reg == S_IDLE);
    assign s_accept = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next    = state_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        bad_next      = bad_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        res_next      = res_reg;
        inv_next      = inv_reg;
        mod_req.start = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    x_next   = s_first_operand[MAG_WIDTH-1:0];
                    y_next   = s_second_operand[MAG_WIDTH-1:0];
                    bad_next = s_first_operand[DATA_WIDTH-1]
                             | s_second_operand[DATA_WIDTH-1];
                    state_next = (bad_next) ? S_DONE : S_START;
                end
            end
            S_START: begin
                if (y_reg == '0) begin
                    state_next = S_DONE;
                end else begin
                    mod_req.start = 1'b1;
                    state_next    = S_WAIT;
                end
            end
            S_WAIT: begin
                if (mod_stat.done) begin
                    x_next     = y_reg;
                    y_next     = mod_rem;
                    state_next = S_START;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    res_next     = bad_reg ? '0 : x_reg;
                    inv_next     = bad_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        x_reg   <= x_next;
        y_reg   <= y_next;
        bad_reg <= bad_next;
        res_reg <= res_next;
        inv_reg <= inv_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_divisor_result = res_reg;
    assign m_invalid_arg    = inv_reg;

endmodule

[rtl/egcd_mod_unit.sv]
`timescale 1ns / 1ps

// Restoring remainder unit: one dividend bit per cycle.
module egcd_mod_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  egcd_pkg::mod_req_t  req,
    input  egcd_pkg::mag_t      dividend,
    input  egcd_pkg::mag_t      divisor,
    output egcd_pkg::mod_stat_t stat,
    output egcd_pkg::mag_t      remainder
);
    import egcd_pkg::*;

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    bit_cnt_t         cnt_reg, cnt_next;
    mag_t             rem_reg, rem_next;
    mag_t             dvd_reg, dvd_next;
    mag_t             dsr_reg, dsr_next;
    logic [MAG_WIDTH:0] shifted;
    logic [MAG_WIDTH:0] diff;

    assign shifted = {rem_reg, dvd_reg[MAG_WIDTH-1]};
    assign diff    = shifted - {1'b0, dsr_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        if (busy_reg) begin
            // shifted < 2*divisor, so one conditional subtract suffices
            if (shifted >= {1'b0, dsr_reg}) begin
                rem_next = diff[MAG_WIDTH-1:0];
            end else begin
                rem_next = shifted[MAG_WIDTH-1:0];
            end
            dvd_next = {dvd_reg[MAG_WIDTH-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end else if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_WIDTH'(MAG_WIDTH - 1);
            rem_next  = '0;
            dvd_next  = dividend;
            dsr_next  = divisor;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign remainder = rem_reg;

endmodule

[rtl/egcd_checker.sv]
`timescale 1ns / 1ps

module egcd_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_valid,
    input logic                            s_ready,
    input logic [egcd_pkg::DATA_WIDTH-1:0] s_first_operand,
    input logic [egcd_pkg::DATA_WIDTH-1:0] s_second_operand,
    input logic                            m_valid,
    input logic                            m_ready,
    input logic [egcd_pkg::MAG_WIDTH-1:0]  m_divisor_result,
    input logic                            m_invalid_arg
);
    import egcd_pkg::*;

    // an invalid item always carries a zero result
    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_invalid_arg |-> m_divisor_result == '0)
        else $error("invalid item with nonzero result");

    // one item at a time: ready drops right after an accept
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while previous item in flight");

    // a waiting input item keeps its operands until taken
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=>
            s_valid && $stable({s_first_operand, s_second_operand}))
        else $error("input item changed before accept");

    // a pending result is held until taken
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped before accept");

    // reset leaves the block idle and empty
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> s_ready && !m_valid)
        else $error("not idle after reset");

endmodule

bind euclid_gcd_unit egcd_checker u_egcd_checker (.*);

[sim/gcd_result_checker.sv]
`timescale 1ns / 1ps

module gcd_result_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  logic [egcd_pkg::DATA_WIDTH-1:0] s_first_operand,
    input  logic [egcd_pkg::DATA_WIDTH-1:0] s_second_operand,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  egcd_pkg::mag_t                  m_divisor_result,
    input  logic                            m_invalid_arg,
    output int unsigned                     pending_items,
    output int unsigned                     fail_count
);
    import egcd_pkg::*;

    typedef struct packed {
        mag_t divisor;
        logic invalid;
    } gcd_result_t;

    gcd_result_t gcd_expected[$];

    function automatic gcd_result_t expected_gcd(input logic [DATA_WIDTH-1:0] a,
                                                 input logic [DATA_WIDTH-1:0] b);
        logic [DATA_WIDTH-1:0] x;
        logic [DATA_WIDTH-1:0] y;
        logic [DATA_WIDTH-1:0] r;
        gcd_result_t           res;
        x = a;
        y = b;
        if (a[DATA_WIDTH-1] || b[DATA_WIDTH-1]) begin
            res.divisor = '0;
            res.invalid = 1'b1;
        end else begin
            while (y != '0) begin
                r = x % y;
                x = y;
                y = r;
            end
            res.divisor = x[MAG_WIDTH-1:0];
            res.invalid = 1'b0;
        end
        return res;
    endfunction

    always @(posedge aclk) begin
        gcd_result_t want;
        if (aresetn) begin
            if (s_valid && s_ready)
                gcd_expected.push_back(expected_gcd(s_first_operand, s_second_operand));
            if (m_valid && m_ready) begin
                if (gcd_expected.size() == 0) begin
                    $display("%0t: unexpected result divisor=%0d invalid=%0b",
                             $time, m_divisor_result, m_invalid_arg);
                    fail_count = fail_count + 1;
                end else begin
                    want = gcd_expected.pop_front();
                    if (m_divisor_result !== want.divisor) begin
                        $display("%0t: divisor_result expected %0d actual %0d",
                                 $time, want.divisor, m_divisor_result);
                        fail_count = fail_count + 1;
                    end
                    if (m_invalid_arg !== want.invalid) begin
                        $display("%0t: invalid_arg expected %0b actual %0b",
                                 $time, want.invalid, m_invalid_arg);
                        fail_count = fail_count + 1;
                    end
                end
            end
            pending_items = gcd_expected.size();
        end else begin
            gcd_expected.delete();
            pending_items = 0;
            fail_count    = 0;
        end
    end

endmodule

[sim/euclid_gcd_unit_tb.sv]
`timescale 1ns / 1ps

module euclid_gcd_unit_tb;
    import egcd_pkg::*;

    localparam int          ITEMS_PER_PHASE = 200;
    localparam int          DRAIN_CYCLES    = 1600; // worst case ~45 remainder steps
    localparam int unsigned CYCLE_LIMIT     = 4_000_000;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic [DATA_WIDTH-1:0] s_first_operand;
    logic [DATA_WIDTH-1:0] s_second_operand;
    logic                  m_valid;
    logic                  m_ready;
    mag_t                  m_divisor_result;
    logic                  m_invalid_arg;

    int unsigned pending_items;
    int unsigned fail_count;
    int unsigned cycle_cnt;
    int unsigned snd_idle_pct;
    int unsigned rcv_idle_pct;

    euclid_gcd_unit u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_first_operand  (s_first_operand),
        .s_second_operand (s_second_operand),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_divisor_result (m_divisor_result),
        .m_invalid_arg    (m_invalid_arg)
    );

    gcd_result_checker u_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_first_operand  (s_first_operand),
        .s_second_operand (s_second_operand),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_divisor_result (m_divisor_result),
        .m_invalid_arg    (m_invalid_arg),
        .pending_items    (pending_items),
        .fail_count       (fail_count)
    );

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= rcv_idle_pct);
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // called and returns at a falling edge; valid stays up between back-to-back items
    task automatic offer_operands(input logic [DATA_WIDTH-1:0] a,
                                  input logic [DATA_WIDTH-1:0] b);
        while ($urandom_range(99) < snd_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid          <= 1'b1;
        s_first_operand  <= a;
        s_second_operand <= b;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic wait_all_results();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (pending_items != 0)
            @(negedge aclk);
    endtask

    function automatic logic [DATA_WIDTH-1:0] pick_operand();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 8)
            return 32'h8000_0000 | $urandom();
        else if (sel < 12)
            return '0;
        else if (sel < 40)
            return $urandom_range(1000, 1);
        else if (sel < 48)
            return 32'h7FFF_FFFF - $urandom_range(15, 0);
        else
            return $urandom() & 32'h7FFF_FFFF;
    endfunction

    initial begin
        logic [DATA_WIDTH-1:0] dir_a[$];
        logic [DATA_WIDTH-1:0] dir_b[$];
        logic [DATA_WIDTH-1:0] a;
        logic [DATA_WIDTH-1:0] b;
        int unsigned           g;

        aresetn          = 1'b0;
        s_valid          = 1'b0;
        s_first_operand  = '0;
        s_second_operand = '0;
        snd_idle_pct     = 0;
        rcv_idle_pct     = 0;

        dir_a = '{32'd0, 32'd0, 32'd1, 32'd0, 32'h7FFF_FFFF, 32'd1,
                  32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd1836311903, 32'd1134903170,
                  32'd12, 32'd18, 32'd17, 32'd1000000007, 32'd48,
                  32'hFFFF_FFFF, 32'd5, 32'h8000_0000, 32'd3, 32'h8000_0000,
                  32'hFFFF_FFFF, 32'h8000_0000, 32'd0};
        dir_b = '{32'd0, 32'd1, 32'd0, 32'h7FFF_FFFF, 32'd0, 32'd1,
                  32'h7FFF_FFFF, 32'h7FFF_FFFE, 32'd1134903170, 32'd1836311903,
                  32'd18, 32'd12, 32'd13, 32'd998244353, 32'h3000_0000,
                  32'd5, 32'hFFFF_FFFF, 32'd3, 32'h8000_0000, 32'h8000_0000,
                  32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF};

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (dir_a[i])
            offer_operands(dir_a[i], dir_b[i]);

        for (int phase = 0; phase < 3; phase++) begin
            // hold off the sender until the block has fully drained
            wait_all_results();
            case (phase)
                0: begin
                    snd_idle_pct = 9;
                    rcv_idle_pct = 86;
                end
                1: begin
                    snd_idle_pct = 86;
                    rcv_idle_pct = 9;
                end
                default: begin
                    snd_idle_pct = 0;
                    rcv_idle_pct = 0;
                end
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if ($urandom_range(99) < 30) begin
                    // pairs sharing a sizable common factor
                    g = $urandom_range(65535, 1);
                    a = g * $urandom_range(32767, 0);
                    b = g * $urandom_range(32767, 0);
                end else begin
                    a = pick_operand();
                    b = pick_operand();
                end
                offer_operands(a, b);
            end
        end

        wait_all_results();
        repeat (DRAIN_CYCLES) @(negedge aclk);

        if (fail_count == 0 && pending_items == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
